@@ rtl/knt_pkg.sv @@
// ============================================================================
// knt_pkg
// Shared types, codes and widths of the keyed node table.
// ============================================================================
package knt_pkg;

    // Default table geometry
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int PAYLOAD_BITS_DEF  = 64;

    // Fixed field widths
    localparam int NODE_ID_BITS       = 32;
    localparam int PAYLOAD_FIELD_BITS = 64;
    localparam int COUNT_FIELD_BITS   = 7;
    localparam int REQ_TYPE_BITS      = 2;
    localparam int STATUS_BITS        = 2;

    // Stream widths
    localparam int S_TDATA_BITS = 96;
    localparam int S_TUSER_BITS = 3;
    localparam int M_TDATA_BITS = 72;
    localparam int M_TUSER_BITS = 3;

    // Request kinds
    localparam logic [REQ_TYPE_BITS-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_TYPE_BITS-1:0] REQ_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_PRESENT   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [PAYLOAD_FIELD_BITS-1:0] payload_in;
        logic                          overwrite;
        logic [NODE_ID_BITS-1:0]       node_id;
        logic [REQ_TYPE_BITS-1:0]      req_type;
    } knt_request_t;

    typedef struct packed {
        logic [COUNT_FIELD_BITS-1:0]   entry_count;
        logic [PAYLOAD_FIELD_BITS-1:0] payload_out;
        logic                          found;
        logic [STATUS_BITS-1:0]        status;
    } knt_result_t;

endpackage

@@ rtl/keyed_node_table.sv @@
// ============================================================================
// keyed_node_table
// Associative table of node ids and payloads with add, remove and lookup.
// ============================================================================
//
//  Channel | Direction | Content
//  --------+-----------+------------------------------------------------
//  s_axis  | in        | one request: kind, node id, overwrite, payload
//  m_axis  | out       | one result: status, found, payload, entry count
//
// A request scans the key memory linearly, one entry a cycle, and then acts;
// a lookup that hits then reads the payload memory as one more step.
// An unused request kind skips the scan.
// After reset a clearing pass over every entry empties the key memory
// before the first request is taken.
// The output register lets the next request start while a result waits.
//
module keyed_node_table
    import knt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // node_id [31:0], payload_in [95:32]
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // req_type [1:0], overwrite [2]
    input  logic [S_TUSER_BITS-1:0] s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // payload_out [63:0], entry_count [70:64], zero [71]
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,
    // status [1:0], found [2]
    output logic [M_TUSER_BITS-1:0] m_axis_tuser
);

    knt_request_t req;
    knt_result_t  res;
    knt_result_t  out_data;
    logic         res_valid;
    logic         res_ready;

    assign req.req_type   = s_axis_tuser[1:0];
    assign req.overwrite  = s_axis_tuser[2];
    assign req.node_id    = s_axis_tdata[31:0];
    assign req.payload_in = s_axis_tdata[95:32];

    knt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAYLOAD_BITS  (PAYLOAD_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    knt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data.entry_count, out_data.payload_out};
    assign m_axis_tuser = {out_data.found, out_data.status};

endmodule

@@ rtl/knt_engine.sv @@
// ============================================================================
// knt_engine
// Key and payload memories with the sequencer that clears, scans and updates
// them, one transaction at a time.
// ============================================================================
module knt_engine
    import knt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PAYLOAD_BITS  = PAYLOAD_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_ready,
    input  knt_request_t req,
    output logic         res_valid,
    input  logic         res_ready,
    output knt_result_t  res
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int KW = NODE_ID_BITS + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ACT,
        ST_LOAD,
        ST_DONE
    } state_t;

    state_t       state_reg, state_next;
    logic [AW-1:0] scan_idx_reg, scan_idx_next;
    logic          eval_vld_reg, eval_vld_next;
    logic [AW-1:0] eval_idx_reg, eval_idx_next;
    logic          hit_reg, hit_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    logic [CW-1:0] count_reg, count_next;
    knt_request_t  req_reg, req_next;
    knt_result_t   res_reg, res_next;

    // Key memory word: valid flag above the node id
    logic [KW-1:0]           key_mem [TABLE_ENTRIES];
    logic [KW-1:0]           key_rdata_reg;
    logic                    key_we;
    logic [AW-1:0]           key_waddr;
    logic [KW-1:0]           key_wdata;
    logic [AW-1:0]           key_raddr;

    logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_rdata_reg;
    logic                    pay_we;
    logic [AW-1:0]           pay_waddr;
    logic [PAYLOAD_BITS-1:0] pay_wdata;
    logic [AW-1:0]           pay_raddr;

    logic slot_match;
    logic slot_empty;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            pay_mem[pay_waddr] <= pay_wdata;
        end
        pay_rdata_reg <= pay_mem[pay_raddr];
    end

    assign slot_match = eval_vld_reg && key_rdata_reg[KW-1]
                        && (key_rdata_reg[NODE_ID_BITS-1:0] == req_reg.node_id);
    assign slot_empty = eval_vld_reg && !key_rdata_reg[KW-1];

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        eval_vld_next = (state_reg == ST_SCAN);
        eval_idx_next = scan_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        count_next    = count_reg;
        req_next      = req_reg;
        res_next      = res_reg;

        key_we    = 1'b0;
        key_waddr = scan_idx_reg;
        key_wdata = '0;
        key_raddr = scan_idx_reg;
        pay_we    = 1'b0;
        pay_waddr = hit_idx_reg;
        pay_wdata = req_reg.payload_in[PAYLOAD_BITS-1:0];
        pay_raddr = hit_idx_reg;

        // Only the lowest-numbered match and free slot are kept.
        if (slot_match && !hit_reg)
        begin
            hit_next     = 1'b1;
            hit_idx_next = eval_idx_reg;
        end
        if (slot_empty && !free_reg)
        begin
            free_next     = 1'b1;
            free_idx_next = eval_idx_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                key_we = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    hit_next      = 1'b0;
                    free_next     = 1'b0;
                    scan_idx_next = '0;
                    if (req.req_type inside {REQ_ADD, REQ_REMOVE, REQ_LOOKUP})
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        res_next.status      = STATUS_OK;
                        res_next.found       = 1'b0;
                        res_next.payload_out = '0;
                        res_next.entry_count = COUNT_FIELD_BITS'(count_reg);
                        state_next           = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                res_next.status      = STATUS_OK;
                res_next.found       = hit_reg;
                res_next.payload_out = '0;
                state_next           = ST_DONE;
                case (req_reg.req_type)
                    REQ_ADD:
                    begin
                        if (hit_reg)
                        begin
                            if (req_reg.overwrite)
                            begin
                                pay_we    = 1'b1;
                                pay_waddr = hit_idx_reg;
                            end
                            else
                            begin
                                res_next.status = STATUS_PRESENT;
                            end
                        end
                        else if (free_reg)
                        begin
                            key_we     = 1'b1;
                            key_waddr  = free_idx_reg;
                            key_wdata  = {1'b1, req_reg.node_id};
                            pay_we     = 1'b1;
                            pay_waddr  = free_idx_reg;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            key_we    = 1'b1;
                            key_waddr = hit_idx_reg;
                            key_wdata = '0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            res_next.status = STATUS_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // Lookup: a hit fetches the payload in the next cycle.
                        if (hit_reg)
                        begin
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            res_next.status = STATUS_NOT_FOUND;
                        end
                    end
                endcase
                res_next.entry_count = COUNT_FIELD_BITS'(count_next);
            end
            ST_LOAD:
            begin
                res_next.payload_out = PAYLOAD_FIELD_BITS'(pay_rdata_reg);
                state_next           = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            scan_idx_reg <= '0;
            eval_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            eval_vld_reg <= eval_vld_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        req_reg      <= req_next;
        res_reg      <= res_next;
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

@@ rtl/knt_out_buf.sv @@
// ============================================================================
// knt_out_buf
// Output register that holds a finished result until the sink takes it.
// ============================================================================
module knt_out_buf
    import knt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    output logic        res_ready,
    input  knt_result_t res,
    output logic        out_valid,
    input  logic        out_ready,
    output knt_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    knt_result_t out_data_reg, out_data_next;

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ test/testbench.sv @@
// ============================================================================
// testbench
// Self-checking test of keyed_node_table over its request and result streams.
// A shadow copy of the table predicts the result of every accepted request.
// A directed table of requests comes first and covers the empty table, key
// zero, an all-ones key, overwrite and the unused request kind. Random
// requests follow in three phases: filling for FILL_UNTIL requests, a mixed
// phase, and draining. Both sides idle in short random bursts, and the
// receiver holds off once for a long stretch so that the block stalls.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import knt_pkg::*;

    localparam logic [REQ_TYPE_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam int TABLE_SLOTS   = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS  = 800;
    localparam int FILL_UNTIL    = 300;
    localparam int DRAIN_FROM    = 550;
    localparam int CALM_FROM     = 700;
    localparam int KEY_POOL_SIZE = 80;
    localparam int HOLD_CYCLES   = 600;
    localparam int TAIL_CYCLES   = 80;

    typedef struct {
        knt_request_t req;
        bit           typed;
        knt_result_t  want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // node_id [31:0], payload_in [95:32]
    logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;
    // req_type [1:0], overwrite [2]
    logic [S_TUSER_BITS-1:0] s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // payload_out [63:0], entry_count [70:64], zero [71]
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    // status [1:0], found [2]
    logic [M_TUSER_BITS-1:0] m_axis_tuser;

    // Shadow copy of the table.
    bit                            shadow_valid   [TABLE_SLOTS];
    logic [NODE_ID_BITS-1:0]       shadow_key     [TABLE_SLOTS];
    logic [PAYLOAD_FIELD_BITS-1:0] shadow_payload [TABLE_SLOTS];
    logic [COUNT_FIELD_BITS-1:0]   shadow_count = '0;

    knt_result_t             pending_results [$];
    plan_row_t               directed_plan [$];
    logic [NODE_ID_BITS-1:0] key_pool [KEY_POOL_SIZE];
    int                      accepted_count = 0;
    int                      error_count    = 0;
    bit                      final_stretch  = 1'b0;
    logic                    hold_off       = 1'b0;

    keyed_node_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    // Applies one request to the shadow table and returns the result it causes.
    // The lowest-numbered matching slot and the lowest-numbered free slot win.
    function automatic knt_result_t apply_to_shadow_table(input knt_request_t r);
        knt_result_t res;
        int          hit;
        int          free_slot;
        res       = '0;
        hit       = -1;
        free_slot = -1;
        if (r.req_type == REQ_UNUSED)
        begin
            res.entry_count = shadow_count;
            return res;
        end
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (shadow_valid[i] && shadow_key[i] == r.node_id)
                hit = i;
            if (!shadow_valid[i])
                free_slot = i;
        end
        res.found = (hit >= 0);
        case (r.req_type)
            REQ_ADD:
            begin
                if (hit >= 0)
                begin
                    if (r.overwrite)
                        shadow_payload[hit] = r.payload_in;
                    else
                        res.status = STATUS_PRESENT;
                end
                else if (free_slot < 0)
                    res.status = STATUS_FULL;
                else
                begin
                    shadow_valid[free_slot]   = 1'b1;
                    shadow_key[free_slot]     = r.node_id;
                    shadow_payload[free_slot] = r.payload_in;
                    shadow_count++;
                end
            end
            REQ_REMOVE:
            begin
                if (hit >= 0)
                begin
                    shadow_valid[hit] = 1'b0;
                    shadow_count--;
                end
                else
                    res.status = STATUS_NOT_FOUND;
            end
            default:
            begin
                if (hit >= 0)
                    res.payload_out = shadow_payload[hit];
                else
                    res.status = STATUS_NOT_FOUND;
            end
        endcase
        res.entry_count = shadow_count;
        return res;
    endfunction

    task automatic add_row(input logic [1:0] kind, input logic [31:0] id, input logic ovw,
                           input logic [63:0] pay, input bit typed, input logic [1:0] st,
                           input logic fnd, input logic [63:0] pout, input logic [6:0] cnt);
        plan_row_t row;
        row.req.req_type      = kind;
        row.req.node_id       = id;
        row.req.overwrite     = ovw;
        row.req.payload_in    = pay;
        row.typed             = typed;
        row.want.status       = st;
        row.want.found        = fnd;
        row.want.payload_out  = pout;
        row.want.entry_count  = cnt;
        directed_plan.push_back(row);
    endtask

    task automatic build_directed_plan();
        add_row(REQ_LOOKUP, 32'h0, 1'b0, '0, 1, STATUS_NOT_FOUND, 1'b0, '0, 7'd0);
        add_row(REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, '1, 1, STATUS_NOT_FOUND, 1'b0, '0, 7'd0);
        add_row(REQ_UNUSED, 32'h0, 1'b0, '0, 1, STATUS_OK, 1'b0, '0, 7'd0);
        add_row(REQ_ADD, 32'h0, 1'b0, '1, 1, STATUS_OK, 1'b0, '0, 7'd1);
        add_row(REQ_LOOKUP, 32'h0, 1'b0, '0, 1, STATUS_OK, 1'b1, '1, 7'd1);
        add_row(REQ_ADD, 32'h0, 1'b0, '0, 1, STATUS_PRESENT, 1'b1, '0, 7'd1);
        add_row(REQ_LOOKUP, 32'h0, 1'b0, '0, 1, STATUS_OK, 1'b1, '1, 7'd1);
        add_row(REQ_ADD, 32'h0, 1'b1, '0, 1, STATUS_OK, 1'b1, '0, 7'd1);
        add_row(REQ_LOOKUP, 32'h0, 1'b1, '1, 1, STATUS_OK, 1'b1, '0, 7'd1);
        // Overwrite on an absent id is an ordinary add.
        add_row(REQ_ADD, 32'hFFFF_FFFF, 1'b1, 64'h5555_5555_5555_5555, 1,
                STATUS_OK, 1'b0, '0, 7'd2);
        add_row(REQ_LOOKUP, 32'hFFFF_FFFF, 1'b0, '0, 1,
                STATUS_OK, 1'b1, 64'h5555_5555_5555_5555, 7'd2);
        add_row(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1, '1, 1, STATUS_OK, 1'b0, '0, 7'd2);
        add_row(REQ_REMOVE, 32'h0, 1'b0, '0, 1, STATUS_OK, 1'b1, '0, 7'd1);
        add_row(REQ_LOOKUP, 32'h0, 1'b0, '0, 1, STATUS_NOT_FOUND, 1'b0, '0, 7'd1);
        add_row(REQ_ADD, 32'hAAAA_AAAA, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, '0, '0, '0);
        add_row(REQ_ADD, 32'h1234_5678, 1'b0, {$urandom, $urandom}, 0, '0, '0, '0, '0);
        add_row(REQ_REMOVE, 32'hFFFF_FFFF, 1'b0, '0, 1, STATUS_OK, 1'b1, '0, 7'd2);
        // Key zero goes back into the lowest free slot.
        add_row(REQ_ADD, 32'h0, 1'b0, {$urandom, $urandom}, 0, '0, '0, '0, '0);
        add_row(REQ_LOOKUP, 32'hAAAA_AAAA, 1'b0, '0, 0, '0, '0, '0, '0);
        add_row(REQ_LOOKUP, 32'h1234_5678, 1'b1, '1, 0, '0, '0, '0, '0);
        add_row(REQ_REMOVE, 32'h5555_5555, 1'b0, '0, 0, '0, '0, '0, '0);
    endtask

    // Mostly ids from a small pool so that hits, a full table and repeats are
    // common; the rest are fresh random ids.
    function automatic knt_request_t random_request(input int idx);
        knt_request_t r;
        int           roll;
        roll         = $urandom_range(99);
        r.payload_in = {$urandom, $urandom};
        r.overwrite  = ($urandom_range(3) == 0);
        if ($urandom_range(9) == 0)
            r.node_id = $urandom;
        else
            r.node_id = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        if (roll < 2)
            r.req_type = REQ_UNUSED;
        else if (idx < FILL_UNTIL)
            r.req_type = (roll < 72) ? REQ_ADD : (roll < 82) ? REQ_REMOVE : REQ_LOOKUP;
        else if (idx < DRAIN_FROM)
            r.req_type = (roll < 42) ? REQ_ADD : (roll < 70) ? REQ_REMOVE : REQ_LOOKUP;
        else
            r.req_type = (roll < 15) ? REQ_ADD : (roll < 75) ? REQ_REMOVE : REQ_LOOKUP;
        return r;
    endfunction

    task automatic send_request(input knt_request_t r, input bit typed,
                                input knt_result_t want, input bit calm);
        knt_result_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.payload_in, r.node_id};
        s_axis_tuser  <= {r.overwrite, r.req_type};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_to_shadow_table(r);
        pending_results.push_back(typed ? want : predicted);
        accepted_count++;
        if (!calm && $urandom_range(4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic check_result();
        knt_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("transaction with no request outstanding",
                            m_axis_tdata[63:0], '0);
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tuser[1:0] !== want.status)
            report_mismatch("status", 64'(m_axis_tuser[1:0]), 64'(want.status));
        if (m_axis_tuser[2] !== want.found)
            report_mismatch("found", 64'(m_axis_tuser[2]), 64'(want.found));
        if (m_axis_tdata[63:0] !== want.payload_out)
            report_mismatch("payload_out", m_axis_tdata[63:0], want.payload_out);
        if (m_axis_tdata[70:64] !== want.entry_count)
            report_mismatch("entry_count", 64'(m_axis_tdata[70:64]), 64'(want.entry_count));
    endtask

    // Request side and end of run.
    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        build_directed_plan();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_plan[i])
            send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want,
                         1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            final_stretch = (n >= CALM_FROM);
            send_request(random_request(n), 1'b0, '0, final_stretch);
        end
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Result side: checks each transaction and stalls in short random bursts.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_result();
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!final_stretch && $urandom_range(5) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // One long hold-off on the result side while requests keep coming, so
    // that the output register fills and the block stops taking requests.
    initial
    begin
        wait (accepted_count >= 150);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
